// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hcpr_pkg.sv =====
// ----------------------------------------------------------------------------
// hcpr_pkg
// Request and response types and fixed constants of the color parser readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcpr_pkg;

  // Request kinds
  localparam logic [1:0] REQ_CHAR  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  // Transfer positions
  localparam logic [2:0] IDX_BUTTONS = 3'd0;
  localparam logic [2:0] IDX_RED     = 3'd1;
  localparam logic [2:0] IDX_GREEN   = 3'd2;
  localparam logic [2:0] IDX_BLUE    = 3'd3;
  localparam logic [2:0] IDX_LIMIT   = 3'd4;

  localparam logic [1:0] DIGIT_POS_FIRST = 2'd2;
  localparam logic [1:0] CHAN_BLUE       = 2'd2;
  localparam logic [7:0] PAST_END_BYTE   = 8'hFF;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [7:0] buttons;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       not_ready;
  } rsp_t;

  // Upper-case hex digit value; anything else counts as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/hex_color_parser_readout.sv =====
// ----------------------------------------------------------------------------
// hex_color_parser_readout
// Parses serial hex characters into 8-bit R/G/B values and serves the latest
// latched triple, preceded by the buttons byte, to a byte-wide bus reader.
// ----------------------------------------------------------------------------
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   request | req_valid/req_ready  | req_data  (req_type, char_code, buttons)
//   response| rsp_valid/rsp_ready  | rsp_data  (read_data, not_ready)
//
// One request per cycle while req_ready is high: decode, shift-in and saturate
// are combinational, ahead of the response register; only bus reads produce a response.
// Reset clears the parser, the readout registers and the transfer index.
// req_ready drops only while a response sits in the output register and
// rsp_ready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_color_parser_readout
  import hcpr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  logic [11:0] digit_accum, digit_accum_next;
  logic [1:0]  digit_pos, digit_pos_next;
  logic [1:0]  channel_sel, channel_sel_next;
  logic [7:0]  pending_rgb [3];
  logic [7:0]  latched_rgb [3];
  logic        fresh_flag, fresh_flag_next;
  logic [2:0]  read_index, read_index_next;

  logic        req_fire;
  logic        is_char, is_read, is_start;
  logic [3:0]  digit;
  logic [11:0] accum_or;
  logic [10:0] half;
  logic [7:0]  chan_value;
  logic        value_done, triple_done, latch_en;
  logic        read_of_blue;
  rsp_t        rsp_next;

  // Accept whenever the response register is free or draining
  assign req_ready = !rsp_valid || rsp_ready;
  assign req_fire  = req_valid && req_ready;
  assign is_char   = req_fire && (req_data.req_type == REQ_CHAR);
  assign is_read   = req_fire && (req_data.req_type == REQ_READ);
  assign is_start  = req_fire && (req_data.req_type == REQ_START);

  // Place the digit at its nibble, most significant first
  assign digit = hex_value(req_data.char_code);
  always_comb begin
    accum_or = digit_accum;
    unique case (digit_pos)
      2'd0:    accum_or[3:0]  = digit_accum[3:0]  | digit;
      2'd1:    accum_or[7:4]  = digit_accum[7:4]  | digit;
      2'd2:    accum_or[11:8] = digit_accum[11:8] | digit;
      default: accum_or = digit_accum;
    endcase
  end

  // Halve and saturate to a byte
  assign half        = accum_or[11:1];
  assign chan_value  = (|half[10:8]) ? 8'hFF : half[7:0];
  assign value_done  = is_char && (digit_pos == 2'd0);
  assign triple_done = value_done && (channel_sel == CHAN_BLUE);
  assign latch_en    = triple_done && !fresh_flag;

  // Parser next state
  always_comb begin
    digit_accum_next = digit_accum;
    digit_pos_next   = digit_pos;
    channel_sel_next = channel_sel;
    if (is_char) begin
      if (digit_pos != 2'd0) begin
        digit_accum_next = accum_or;
        digit_pos_next   = digit_pos - 2'd1;
      end else begin
        digit_accum_next = 12'd0;
        digit_pos_next   = DIGIT_POS_FIRST;
        channel_sel_next = (channel_sel == CHAN_BLUE) ? 2'd0 : channel_sel + 2'd1;
      end
    end
  end

  // Readout next state and response
  always_comb begin
    fresh_flag_next = fresh_flag;
    read_index_next = read_index;
    rsp_next        = '{read_data: 8'd0, not_ready: 1'b1};
    if (triple_done) begin
      fresh_flag_next = 1'b1;
    end
    if (is_start) begin
      read_index_next = IDX_BUTTONS;
    end
    if (is_read && fresh_flag) begin
      rsp_next.not_ready = 1'b0;
      unique case (read_index)
        IDX_BUTTONS: rsp_next.read_data = req_data.buttons;
        IDX_RED:     rsp_next.read_data = latched_rgb[0];
        IDX_GREEN:   rsp_next.read_data = latched_rgb[1];
        IDX_BLUE: begin
          rsp_next.read_data = latched_rgb[2];
          fresh_flag_next    = 1'b0;
        end
        default:     rsp_next.read_data = PAST_END_BYTE;
      endcase
      read_index_next = (read_index < IDX_LIMIT) ? read_index + 3'd1 : IDX_LIMIT;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_accum <= 12'd0;
      digit_pos   <= DIGIT_POS_FIRST;
      channel_sel <= 2'd0;
      fresh_flag  <= 1'b0;
      read_index  <= IDX_BUTTONS;
      for (int i = 0; i < 3; i++) begin
        pending_rgb[i] <= 8'd0;
        latched_rgb[i] <= 8'd0;
      end
    end else begin
      digit_accum <= digit_accum_next;
      digit_pos   <= digit_pos_next;
      channel_sel <= channel_sel_next;
      fresh_flag  <= fresh_flag_next;
      read_index  <= read_index_next;
      if (value_done && (channel_sel != 2'd3)) begin
        pending_rgb[channel_sel] <= chan_value;
      end
      if (latch_en) begin
        latched_rgb[0] <= pending_rgb[0];
        latched_rgb[1] <= pending_rgb[1];
        latched_rgb[2] <= chan_value;
      end
    end
  end

  // Response register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_ready) begin
      rsp_valid <= is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      rsp_data <= rsp_next;
    end
  end

  // Bus read at the blue position
  assign read_of_blue = is_read && (read_index == IDX_BLUE);

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_index_range, read_index <= IDX_LIMIT, "read index past limit")
  `ASSERT_ALWAYS(a_pos_range, digit_pos != 2'd3, "digit position out of range")
  `ASSERT_ALWAYS(a_chan_range, channel_sel != 2'd3, "channel select out of range")
  `ASSERT_NEXT(a_read_responds, is_read, rsp_valid, "bus read produced no response")
  `ASSERT_IMPLY(a_fresh_clear, $fell(fresh_flag), $past(read_of_blue), "fresh cleared early")

endmodule

// ===== tb/hex_color_parser_readout_test.sv =====
// ----------------------------------------------------------------------------
// hex_color_parser_readout_test
// Drives serial characters, transfer starts and bus reads into the color
// parser readout and checks every read response against an in-bench model of
// the parser, the readout registers, the fresh flag and the transfer index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_color_parser_readout_test;
  import hcpr_pkg::*;

  // Request kind that the block ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned HOLD_OFF_CYCLES = 64;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned ITEM_GOAL       = 1900;
  localparam string       HEX_DIGITS      = "0123456789ABCDEF";

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  // Color parser model state
  logic [11:0] acc_value;
  logic [1:0]  next_digit;
  logic [1:0]  cur_channel;
  logic [7:0]  parsed_rgb [3];
  logic [7:0]  shown_rgb [3];
  logic        triple_waiting;
  logic [2:0]  xfer_pos;

  rsp_t        expected_rsp [$];
  rsp_t        oldest;

  bit          idling_on = 1'b0;
  bit          hold_off_request = 1'b0;
  int unsigned items_sent = 0;
  int unsigned rsp_checked = 0;
  int unsigned not_ready_seen = 0;
  int unsigned triples_done = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  hex_color_parser_readout i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // Map an upper-case hex digit to its value; anything else is zero
  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= "0" && c <= "9") begin
      v = c - "0";
    end else if (c >= "A" && c <= "F") begin
      v = c - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

  task automatic model_reset();
    acc_value      = '0;
    next_digit     = DIGIT_POS_FIRST;
    cur_channel    = '0;
    parsed_rgb     = '{default: 8'h00};
    shown_rgb      = '{default: 8'h00};
    triple_waiting = 1'b0;
    xfer_pos       = IDX_BUTTONS;
  endtask

  // Advance the model by one accepted request; queue the response of a read
  task automatic model_request(input req_t r);
    logic [11:0] half;
    rsp_t        want;
    want = '0;
    case (r.req_type)
      REQ_CHAR: begin
        acc_value = acc_value | ({8'h00, digit_of(r.char_code)} << {next_digit, 2'b00});
        if (next_digit != 2'd0) begin
          next_digit = next_digit - 2'd1;
        end else begin
          next_digit = DIGIT_POS_FIRST;
          half = acc_value >> 1;
          parsed_rgb[cur_channel] = (half > 12'h0FF) ? 8'hFF : half[7:0];
          acc_value = '0;
          if (cur_channel == CHAN_BLUE) begin
            cur_channel = '0;
            triples_done++;
            // keep the old triple while the reader has not consumed it
            if (!triple_waiting) begin
              shown_rgb = parsed_rgb;
            end
            triple_waiting = 1'b1;
          end else begin
            cur_channel = cur_channel + 2'd1;
          end
        end
      end
      REQ_START: begin
        xfer_pos = IDX_BUTTONS;
      end
      REQ_READ: begin
        if (!triple_waiting) begin
          want.not_ready = 1'b1;
        end else begin
          case (xfer_pos)
            IDX_BUTTONS: want.read_data = r.buttons;
            IDX_RED:     want.read_data = shown_rgb[0];
            IDX_GREEN:   want.read_data = shown_rgb[1];
            IDX_BLUE: begin
              want.read_data = shown_rgb[2];
              triple_waiting = 1'b0;
            end
            default:     want.read_data = PAST_END_BYTE;
          endcase
          if (xfer_pos < IDX_LIMIT) begin
            xfer_pos = xfer_pos + 3'd1;
          end
        end
        expected_rsp.push_back(want);
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Response side: ready driver, checker, watchdog
  // --------------------------------------------------------------------------

  // Drive rsp_ready: long hold-off on request, random stall bursts, else ready
  always begin
    @(posedge clk);
    if (hold_off_request) begin
      rsp_ready <= 1'b0;
      repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      hold_off_request = 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      rsp_ready <= 1'b0;
      repeat ($urandom_range(1, 5) - 1) @(posedge clk);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  task automatic note_mismatch(input string what, input logic [7:0] want_v,
                               input logic [7:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: mismatch on %s: expected %02h, got %02h", $realtime, what, want_v, got_v);
    end
  endtask

  // Compare each accepted response with the oldest expected one
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        note_mismatch("unexpected response read_data", 8'h00, rsp_data.read_data);
      end else begin
        oldest = expected_rsp.pop_front();
        rsp_checked++;
        if (oldest.not_ready) begin
          not_ready_seen++;
        end
        if (rsp_data.read_data !== oldest.read_data) begin
          note_mismatch("read_data", oldest.read_data, rsp_data.read_data);
        end
        if (rsp_data.not_ready !== oldest.not_ready) begin
          note_mismatch("not_ready", {7'd0, oldest.not_ready}, {7'd0, rsp_data.not_ready});
        end
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no request or response moved for %0d cycles", STALL_LIMIT);
      $display("hex_color_parser_readout_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request, with an optional idle burst first, and wait for it
  task automatic send_request(input req_t r);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    model_request(r);
    if (r.req_type != REQ_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    req_t r;
    r.req_type  = REQ_CHAR;
    r.char_code = c;
    r.buttons   = 8'($urandom_range(0, 255));
    send_request(r);
  endtask

  task automatic send_read(input logic [7:0] btn);
    req_t r;
    r.req_type  = REQ_READ;
    r.char_code = 8'($urandom_range(0, 255));
    r.buttons   = btn;
    send_request(r);
  endtask

  task automatic send_start();
    req_t r;
    r.req_type  = REQ_START;
    r.char_code = 8'($urandom_range(0, 255));
    r.buttons   = 8'($urandom_range(0, 255));
    send_request(r);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
  endtask

  task automatic send_transfer(input int unsigned reads);
    send_start();
    repeat (reads) send_read(8'($urandom_range(0, 255)));
  endtask

  // Mostly valid upper-case digits, some lower case, some arbitrary bytes
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0:       c = 8'($urandom_range(0, 255));
      1:       c = 8'("a" + $urandom_range(0, 5));
      default: c = HEX_DIGITS[$urandom_range(0, 15)];
    endcase
    return c;
  endfunction

  // Drop valid and hold until every expected response has come back
  task automatic wait_results_done();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Read before any triple, plus the ignored request kind
  task automatic test_no_triple_yet();
    req_t r;
    send_read(8'hFF);
    r.req_type  = REQ_UNUSED;
    r.char_code = 8'hFF;
    r.buttons   = 8'hFF;
    send_request(r);
    send_read(8'h00);
  endtask

  // Saturation, exact 0xFF, invalid characters, triple ignored while fresh
  task automatic test_triple_readout();
    send_text("FFF1FEa:G");
    send_text("@/9");
    send_char(8'h00);
    send_char(8'hFF);
    send_text("7200");
    send_start();
    send_read(8'hFF);
    send_read(8'h00);
    send_read(8'h5A);
    send_read(8'hA5);
    send_read(8'h3C);
  endtask

  // New triple after blue was read, then a read past the end
  task automatic test_past_end();
    send_text("0A95C3E1D");
    send_read(8'h00);
  endtask

  // Hold off the reader so the block fills up and stalls its input
  task automatic test_backpressure();
    hold_off_request = 1'b1;
    send_text("8F0123ABC");
    send_transfer(8);
    send_transfer(8);
    wait_results_done();
  endtask

  // Well-formed triples and transfers with random content, plus noise
  task automatic test_random_traffic(input int unsigned goal, input bit with_idling);
    req_t r;
    idling_on = with_idling;
    while (items_sent < goal) begin
      if ($urandom_range(0, 9) < 7) begin
        repeat (9) send_char(pick_char());
      end
      if ($urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 9) != 0) begin
          send_start();
        end
        repeat ($urandom_range(3, 6)) send_read(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          r.req_type  = 2'($urandom_range(0, 3));
          r.char_code = 8'($urandom_range(0, 255));
          r.buttons   = 8'($urandom_range(0, 255));
          send_request(r);
        end
      end
    end
  endtask

  initial begin
    model_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_no_triple_yet();
    test_triple_readout();
    test_past_end();
    wait_results_done();
    test_backpressure();
    test_random_traffic(ITEM_GOAL * 3 / 5, 1'b1);
    wait_results_done();
    test_random_traffic(ITEM_GOAL, 1'b0);
    wait_results_done();

    $display("covered %0d requests and %0d color triples; checked %0d responses",
             items_sent, triples_done, rsp_checked);
    $display("%0d responses were not-ready, %0d mismatches", not_ready_seen, mismatch_count);
    if (mismatch_count == 0 && expected_rsp.size() == 0) begin
      $display("hex_color_parser_readout_test OK");
    end else begin
      $display("hex_color_parser_readout_test NOT OK");
    end
    $finish;
  end

endmodule
